@@ rtl/lkvc_pkg.sv @@
package lkvc_pkg;

   localparam int KEY_W = 32;
   localparam int VAL_W = 32;
   localparam int CSR_W = 5;

   localparam logic [CSR_W-1:0] CAPACITY_RESET = 5'd10;

   // operation codes
   localparam logic FUNC_GET = 1'b0;
   localparam logic FUNC_PUT = 1'b1;

   // value returned by a get that misses
   localparam logic [VAL_W-1:0] MISS_VALUE = '1;

   // controller -> datapath
   typedef struct packed {
      logic load;     // capture the request item
      logic match;    // compare key against all entries
      logic update;   // apply recency, insert, evict; launch RAM reads
      logic emit;     // load the result register
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_free; // result register is empty or being drained
   } dp_status_type;

endpackage

@@ rtl/lkvc_ram.sv @@
module lkvc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read-first: a read and a write to the same address return the old word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/lkvc_ctrl.sv @@
module lkvc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output lkvc_pkg::dp_cmd_type   cmd,
   input  lkvc_pkg::dp_status_type status
);
   import lkvc_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_MATCH  = 4'b0010,
      S_UPDATE = 4'b0100,
      S_EMIT   = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_MATCH;
            end
         end
         S_MATCH: begin
            cmd.match = 1'b1;
            state_in  = S_UPDATE;
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = S_EMIT;
         end
         S_EMIT: begin
            // hold here until the result register can take the item
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/lkvc_dpath.sv @@
module lkvc_dpath #(
   parameter int ENTRIES = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  lkvc_pkg::dp_cmd_type           cmd,
   output lkvc_pkg::dp_status_type        status,
   input  logic                           req_func,
   input  logic [lkvc_pkg::KEY_W-1:0]     req_key,
   input  logic [lkvc_pkg::VAL_W-1:0]     req_data,
   input  logic                           csr_we,
   input  logic [lkvc_pkg::CSR_W-1:0]     csr_data,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic                           rsp_found,
   output logic [lkvc_pkg::VAL_W-1:0]     rsp_read_value,
   output logic                           rsp_evicted,
   output logic [lkvc_pkg::KEY_W-1:0]     rsp_evicted_key
);
   import lkvc_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int OCC_W = $clog2(ENTRIES + 1);
   localparam int CMP_W = (OCC_W > CSR_W) ? OCC_W : CSR_W;

   // request item
   logic             func_ff, func_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [VAL_W-1:0] data_ff, data_in;

   // configuration
   logic [CSR_W-1:0] capacity_ff, capacity_in;

   // per-entry state
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [IDX_W-1:0]   age_ff [ENTRIES];
   logic [IDX_W-1:0]   age_in [ENTRIES];
   logic [KEY_W-1:0]   tag_ff [ENTRIES];
   logic [OCC_W-1:0]   occ_ff, occ_in;

   // match stage results
   logic [ENTRIES-1:0] hit_vec_ff, hit_vec_in;
   logic [ENTRIES-1:0] victim_vec_ff, victim_vec_in;
   logic               full_ff, full_in;

   // update stage results
   logic found_ff, found_in;
   logic evicted_ff, evicted_in;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_found_ff, rsp_found_in;
   logic [VAL_W-1:0] rsp_value_ff, rsp_value_in;
   logic             rsp_evicted_ff, rsp_evicted_in;
   logic [KEY_W-1:0] rsp_evkey_ff, rsp_evkey_in;

   logic [CMP_W-1:0] cap_ext;
   logic [CMP_W-1:0] cap_eff;
   logic [IDX_W-1:0] oldest_rank;

   logic               hit;
   logic               put_miss;
   logic               do_evict;
   logic [IDX_W-1:0]   hit_idx;
   logic [IDX_W-1:0]   victim_idx;
   logic [IDX_W-1:0]   free_idx;
   logic [IDX_W-1:0]   hit_age;
   logic [ENTRIES-1:0] free_mask;

   logic             val_wr_en;
   logic [IDX_W-1:0] val_wr_addr;
   logic             val_rd_en;
   logic [VAL_W-1:0] val_rd_data;
   logic             key_wr_en;
   logic             key_rd_en;
   logic [KEY_W-1:0] key_rd_data;

   // ---------------------------------------------------------------- capture
   assign func_in     = cmd.load ? req_func : func_ff;
   assign key_in      = cmd.load ? req_key  : key_ff;
   assign data_in     = cmd.load ? req_data : data_ff;
   assign capacity_in = csr_we   ? csr_data : capacity_ff;

   // ---------------------------------------------------------------- match
   // capacity 0 acts as 1, above ENTRIES acts as ENTRIES
   assign cap_ext = CMP_W'(capacity_ff);
   always_comb begin
      priority if (cap_ext == '0) begin
         cap_eff = CMP_W'(1);
      end else if (cap_ext > CMP_W'(ENTRIES)) begin
         cap_eff = CMP_W'(ENTRIES);
      end else begin
         cap_eff = cap_ext;
      end
   end

   // valid ages are a permutation of 0..occ-1, so the oldest has rank occ-1
   assign oldest_rank = IDX_W'(occ_ff - OCC_W'(1));

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         hit_vec_in[i]    = cmd.match ? (valid_ff[i] && (tag_ff[i] == key_ff))
                                      : hit_vec_ff[i];
         victim_vec_in[i] = cmd.match ? (valid_ff[i] && (age_ff[i] == oldest_rank))
                                      : victim_vec_ff[i];
      end
      full_in = cmd.match ? (CMP_W'(occ_ff) >= cap_eff) : full_ff;
   end

   // ---------------------------------------------------------------- update
   assign hit      = |hit_vec_ff;
   assign put_miss = (func_ff == FUNC_PUT) && !hit;
   assign do_evict = put_miss && full_ff && (|victim_vec_ff);
   assign free_mask = ~(valid_ff & ~(do_evict ? victim_vec_ff : '0));

   // lowest set bit of each vector
   always_comb begin
      hit_idx    = '0;
      victim_idx = '0;
      free_idx   = '0;
      hit_age    = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (hit_vec_ff[i]) begin
            hit_idx = IDX_W'(i);
         end
         if (victim_vec_ff[i]) begin
            victim_idx = IDX_W'(i);
         end
         if (free_mask[i]) begin
            free_idx = IDX_W'(i);
         end
      end
      for (int i = 0; i < ENTRIES; i++) begin
         if (hit_vec_ff[i]) begin
            hit_age = hit_age | age_ff[i];
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         age_in[i] = age_ff[i];
         if (cmd.update) begin
            if (hit) begin
               // touch: younger entries age by one, the hit becomes newest
               if (valid_ff[i] && (age_ff[i] < hit_age)) begin
                  age_in[i] = age_ff[i] + IDX_W'(1);
               end
               if (hit_vec_ff[i]) begin
                  age_in[i] = '0;
               end
            end else if (put_miss) begin
               if (do_evict && victim_vec_ff[i]) begin
                  valid_in[i] = 1'b0;
                  age_in[i]   = '0;
               end else if (valid_ff[i]) begin
                  age_in[i] = age_ff[i] + IDX_W'(1);
               end
               if (free_idx == IDX_W'(i)) begin
                  valid_in[i] = 1'b1;
                  age_in[i]   = '0;
               end
            end
         end
      end
   end

   always_comb begin
      occ_in = occ_ff;
      if (cmd.update && put_miss && !do_evict) begin
         occ_in = occ_ff + OCC_W'(1);
      end
   end

   assign found_in   = cmd.update ? hit      : found_ff;
   assign evicted_in = cmd.update ? do_evict : evicted_ff;

   // value store: read on get hit, written on every put
   assign val_rd_en   = cmd.update && (func_ff == FUNC_GET) && hit;
   assign val_wr_en   = cmd.update && (func_ff == FUNC_PUT);
   assign val_wr_addr = hit ? hit_idx : free_idx;

   // key copy for eviction readout; read-first covers victim == free slot
   assign key_rd_en = cmd.update && do_evict;
   assign key_wr_en = cmd.update && put_miss;

   lkvc_ram #(
      .WIDTH (VAL_W),
      .DEPTH (ENTRIES)
   ) u_val_ram (
      .clock   (clock),
      .wr_en   (val_wr_en),
      .wr_addr (val_wr_addr),
      .wr_data (data_ff),
      .rd_en   (val_rd_en),
      .rd_addr (hit_idx),
      .rd_data (val_rd_data)
   );

   lkvc_ram #(
      .WIDTH (KEY_W),
      .DEPTH (ENTRIES)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (free_idx),
      .wr_data (key_ff),
      .rd_en   (key_rd_en),
      .rd_addr (victim_idx),
      .rd_data (key_rd_data)
   );

   // ---------------------------------------------------------------- result
   always_comb begin
      rsp_found_in   = rsp_found_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_evicted_in = rsp_evicted_ff;
      rsp_evkey_in   = rsp_evkey_ff;
      if (cmd.emit) begin
         rsp_found_in   = found_ff;
         rsp_evicted_in = evicted_ff;
         rsp_evkey_in   = evicted_ff ? key_rd_data : '0;
         if (func_ff == FUNC_GET) begin
            rsp_value_in = found_ff ? val_rd_data : MISS_VALUE;
         end else begin
            rsp_value_in = '0;
         end
      end
   end

   assign rsp_valid_in    = cmd.emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAPACITY_RESET;
         valid_ff     <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < ENTRIES; i++) begin
            age_ff[i] <= '0;
         end
      end else begin
         capacity_ff  <= capacity_in;
         valid_ff     <= valid_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < ENTRIES; i++) begin
            age_ff[i] <= age_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      func_ff        <= func_in;
      key_ff         <= key_in;
      data_ff        <= data_in;
      hit_vec_ff     <= hit_vec_in;
      victim_vec_ff  <= victim_vec_in;
      full_ff        <= full_in;
      found_ff       <= found_in;
      evicted_ff     <= evicted_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_evicted_ff <= rsp_evicted_in;
      rsp_evkey_ff   <= rsp_evkey_in;
      if (key_wr_en) begin
         tag_ff[free_idx] <= key_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_read_value  = rsp_value_ff;
   assign rsp_evicted     = rsp_evicted_ff;
   assign rsp_evicted_key = rsp_evkey_ff;

endmodule

@@ rtl/lru_key_value_cache.sv @@
// Fully associative key/value cache with least-recently-used replacement.
//
// req channel: one item per operation. req_tuser is the operation (0 get,
//   1 put); req_tdata carries the key (low word) and the value (high word).
// rsp channel: exactly one item per request, in request order. rsp_tuser
//   bit 0 = key was present, bit 1 = an entry was evicted; rsp_tdata holds
//   the read value (low word) and the evicted key (high word).
// csr channel: writes the capacity register (5 bits, reset 10). Write it
//   only while no request is in flight.
//
// Flow: a request passes the tag match, the recency update with RAM read and
//   the result load, in that order. One request is in flight at a time and
//   the controller walks its idle, match, update and emit states, so the next
//   request is taken only after the previous one has been emitted.
// Reset: synchronous; empties the cache, restores capacity to 10, and
//   drops any pending result. No clearing pass is needed.
// Stall: a result waits in the output register while rsp_tready is low; the
//   next request is taken meanwhile and held at the last stage until the
//   register drains.
module lru_key_value_cache #(
   parameter int ENTRIES = 16
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] lookup_key, [63:32] data_word
   input  logic        req_tuser,   // [0] func

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [31:0] read_value, [63:32] evicted_key
   output logic [1:0]  rsp_tuser,   // [0] found, [1] evicted

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_wdata    // capacity
);
   import lkvc_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   logic             rsp_found;
   logic             rsp_evicted;
   logic [VAL_W-1:0] rsp_read_value;
   logic [KEY_W-1:0] rsp_evicted_key;

   // capacity writes are always taken
   assign csr_ready = 1'b1;

   lkvc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .cmd       (cmd),
      .status    (status)
   );

   lkvc_dpath #(
      .ENTRIES (ENTRIES)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_func        (req_tuser),
      .req_key         (req_tdata[31:0]),
      .req_data        (req_tdata[63:32]),
      .csr_we          (csr_valid),
      .csr_data        (csr_wdata),
      .rsp_ready       (rsp_tready),
      .rsp_valid       (rsp_tvalid),
      .rsp_found       (rsp_found),
      .rsp_read_value  (rsp_read_value),
      .rsp_evicted     (rsp_evicted),
      .rsp_evicted_key (rsp_evicted_key)
   );

   assign rsp_tdata = {rsp_evicted_key, rsp_read_value};
   assign rsp_tuser = {rsp_evicted, rsp_found};

endmodule

@@ rtl/lkvc_checker.sv @@
module lkvc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [63:0] req_tdata,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic [4:0]  csr_wdata
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // one request in flight: no accept in the cycle after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while previous one still in work");

   // evicted key is zero unless an eviction happened
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[1] |-> rsp_tdata[63:32] == 32'd0)
      else $error("evicted key set without eviction");

   // eviction only happens on a miss
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> !rsp_tuser[0])
      else $error("eviction reported on a hit");

   // reset drops any pending result
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (.*);

@@ sim/tb_top.sv @@
module tb_top;
   import lkvc_pkg::*;

   localparam int ENTRIES   = 16;
   localparam int CYCLE_CAP = 200000;  // generous: ~750 items plus stalls
   localparam int DRAIN_CYC = 10;

   typedef struct {
      logic             func;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] data;
   } cache_op_type;

   typedef struct {
      logic             found;
      logic [VAL_W-1:0] read_value;
      logic             evicted;
      logic [KEY_W-1:0] evicted_key;
   } cache_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // [31:0] lookup_key, [63:32] data_word
   logic        req_tuser = 1'b0; // [0] func
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;        // [31:0] read_value, [63:32] evicted_key
   logic [1:0]  rsp_tuser;        // [0] found, [1] evicted
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [4:0]  csr_wdata = '0;   // capacity

   lru_key_value_cache #(.ENTRIES(ENTRIES)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   // items waiting for the driver, and results owed by the cache
   cache_op_type     pending_ops[$];
   cache_result_type owed_results[$];

   // shadow copy of the cache contents
   logic [KEY_W-1:0] line_key[ENTRIES];
   logic [VAL_W-1:0] line_value[ENTRIES];
   logic             line_valid[ENTRIES];
   int               line_age[ENTRIES];   // 0 = most recent
   int               fill;
   logic [4:0]       capacity = CAPACITY_RESET;

   int   mismatches = 0;
   int   cycles = 0;
   logic steady = 1'b0;    // no idling on either side while set
   logic req_fired = 1'b0;

   // Apply one get/put to the shadow cache and return the result it owes.
   function automatic cache_result_type lru_apply(cache_op_type op);
      cache_result_type res;
      int hit, victim, slot, limit, a;
      res.found       = 1'b0;
      res.read_value  = '0;
      res.evicted     = 1'b0;
      res.evicted_key = '0;
      hit = -1;
      for (int i = 0; i < ENTRIES; i++)
         if (hit < 0 && line_valid[i] && line_key[i] == op.key) hit = i;

      if (hit >= 0) begin
         res.found = 1'b1;
         if (op.func == FUNC_GET) res.read_value = line_value[hit];
         else line_value[hit] = op.data;
         // promote: everything younger than the hit ages by one
         a = line_age[hit];
         for (int i = 0; i < ENTRIES; i++)
            if (line_valid[i] && line_age[i] < a) line_age[i]++;
         line_age[hit] = 0;
      end else if (op.func == FUNC_GET) begin
         res.read_value = MISS_VALUE;
      end else begin
         // out-of-range capacity clamps to 1..ENTRIES
         limit = capacity;
         if (limit < 1) limit = 1;
         if (limit > ENTRIES) limit = ENTRIES;
         // only one eviction per miss, even when over capacity
         if (fill >= limit && fill > 0) begin
            victim = -1;
            for (int i = 0; i < ENTRIES; i++)
               if (line_valid[i] && (victim < 0 || line_age[i] > line_age[victim]))
                  victim = i;
            if (victim >= 0) begin
               res.evicted     = 1'b1;
               res.evicted_key = line_key[victim];
               line_valid[victim] = 1'b0;
               line_age[victim]   = 0;
               fill--;
            end
         end
         slot = -1;
         for (int i = 0; i < ENTRIES; i++)
            if (slot < 0 && !line_valid[i]) slot = i;
         if (slot >= 0) begin
            for (int i = 0; i < ENTRIES; i++)
               if (line_valid[i]) line_age[i]++;
            line_valid[slot] = 1'b1;
            line_key[slot]   = op.key;
            line_value[slot] = op.data;
            line_age[slot]   = 0;
            fill++;
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatches < 40)
         $display("mismatch @%0d: %s got %h want %h", cycles, what, got, want);
      mismatches++;
   endtask

   // Driver: new values at the falling edge; one assignment per signal per step.
   always @(negedge clock) begin : driver
      cache_op_type op;
      if (!reset) begin
         rsp_tready <= steady || ($urandom_range(99) >= 10);
         if (!req_tvalid || req_fired) begin
            if (pending_ops.size() != 0 && (steady || $urandom_range(99) >= 10)) begin
               op = pending_ops.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= op.func;
               req_tdata  <= {op.data, op.key};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: sample at the rising edge, check results, predict accepted items.
   always @(posedge clock) begin : monitor
      cache_op_type     op;
      cache_result_type want;
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("[lru_key_value_cache] ERROR");
         $finish;
      end else if (!reset) begin
         req_fired <= req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            if (owed_results.size() == 0) begin
               report_mismatch("unexpected item", rsp_tdata[31:0], '0);
            end else begin
               want = owed_results.pop_front();
               if (rsp_tuser[0] !== want.found)
                  report_mismatch("found", {31'd0, rsp_tuser[0]}, {31'd0, want.found});
               if (rsp_tdata[31:0] !== want.read_value)
                  report_mismatch("read_value", rsp_tdata[31:0], want.read_value);
               if (rsp_tuser[1] !== want.evicted)
                  report_mismatch("evicted", {31'd0, rsp_tuser[1]}, {31'd0, want.evicted});
               if (rsp_tdata[63:32] !== want.evicted_key)
                  report_mismatch("evicted_key", rsp_tdata[63:32], want.evicted_key);
            end
         end
         if (req_tvalid && req_tready) begin
            op.func = req_tuser;
            op.key  = req_tdata[31:0];
            op.data = req_tdata[63:32];
            owed_results.insert(owed_results.size(), lru_apply(op));
         end
      end
   end

   task automatic queue_op(input logic func, input logic [31:0] key,
                           input logic [31:0] data);
      cache_op_type op;
      op.func = func;
      op.key  = key;
      op.data = data;
      pending_ops.insert(pending_ops.size(), op);
   endtask

   // Block until every item is sent and answered, then let the pipe settle.
   task automatic drain_all();
      while (pending_ops.size() != 0 || owed_results.size() != 0 || req_tvalid)
         @(negedge clock);
      repeat (DRAIN_CYC) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [4:0] value);
      drain_all();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      capacity = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Random phase: mostly gets/puts over a key set a bit larger than the
   // capacity (hits, misses and evictions), plus some stray keys.
   task automatic random_phase(input int count, input int pool_size);
      logic [31:0] keys[$];
      logic [31:0] k;
      for (int i = 0; i < pool_size; i++) begin
         case ($urandom_range(7))
            0: k = 32'h8000_0000 ^ $urandom_range(3);
            1: k = 32'h7FFF_FFFF ^ $urandom_range(3);
            2: k = $urandom_range(15);
            default: k = $urandom;
         endcase
         keys.insert(keys.size(), k);
      end
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < 85)
            k = keys[$urandom_range(keys.size() - 1)];
         else
            k = $urandom;
         queue_op($urandom_range(1) ? FUNC_PUT : FUNC_GET, k, $urandom);
      end
   endtask

   initial begin : stimulus
      logic [4:0] caps[8];
      int         eff;
      for (int i = 0; i < ENTRIES; i++) begin
         line_key[i]   = '0;
         line_value[i] = '0;
         line_valid[i] = 1'b0;
         line_age[i]   = 0;
      end
      fill = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty lookup, extreme keys and values, hits on both ops
      queue_op(FUNC_GET, 32'h0000_0000, 32'h0000_0000);
      queue_op(FUNC_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
      queue_op(FUNC_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
      queue_op(FUNC_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_op(FUNC_PUT, 32'h0000_0000, 32'h0000_0000);
      queue_op(FUNC_GET, 32'h8000_0000, 32'hFFFF_FFFF);
      queue_op(FUNC_PUT, 32'h7FFF_FFFF, 32'h1234_5678);
      queue_op(FUNC_GET, 32'h7FFF_FFFF, 32'h0000_0000);
      queue_op(FUNC_GET, 32'h0000_0005, 32'hA5A5_A5A5);  // miss, data ignored
      queue_op(FUNC_GET, 32'hFFFF_FFFF, 32'h0000_0000);

      // capacity dropped under occupancy: each miss evicts only one
      write_capacity(5'd2);
      queue_op(FUNC_PUT, 32'h0000_0001, 32'h1111_1111);
      queue_op(FUNC_PUT, 32'h0000_0002, 32'h2222_2222);
      queue_op(FUNC_PUT, 32'h0000_0003, 32'h3333_3333);
      queue_op(FUNC_GET, 32'h0000_0002, 32'h0000_0000);
      queue_op(FUNC_PUT, 32'h0000_0004, 32'h4444_4444);

      // zero capacity behaves as one
      write_capacity(5'd0);
      queue_op(FUNC_PUT, 32'hDEAD_BEEF, 32'hCAFE_F00D);
      queue_op(FUNC_PUT, 32'h0000_0007, 32'h7777_7777);
      queue_op(FUNC_GET, 32'h0000_0007, 32'h0000_0000);
      queue_op(FUNC_GET, 32'hDEAD_BEEF, 32'h0000_0000);

      // eight random phases over a spread of capacities; 31 clamps to the entry count
      caps = '{5'd31, 5'd3, 5'd1, 5'd16, 5'd5, 5'd0, 5'd12, 5'd10};
      for (int p = 0; p < 8; p++) begin
         write_capacity(caps[p]);
         steady = (p == 3);
         eff = (caps[p] == 0) ? 1 : (caps[p] > ENTRIES) ? ENTRIES : caps[p];
         random_phase(92, eff + 3);
      end

      drain_all();
      if (mismatches == 0)
         $display("[lru_key_value_cache] OK");
      else
         $display("[lru_key_value_cache] ERROR");
      $finish;
   end

endmodule
